/* sv/itp_pkg.sv */
`timescale 1ns / 1ps
package itp_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int SQRT_STEPS   = 24;
	localparam int DIV_STEPS    = 29;
	localparam logic signed [15:0] ANGLE_LIM = 16'sd23040;
	localparam logic signed [32:0] ACC_LIM   = 33'sd11796480;

	localparam logic [1:0] CFG_REFRESH_RATE = 2'd0;
	localparam logic [1:0] CFG_PITCH_OFFSET = 2'd1;
	localparam logic [1:0] CFG_ROLL_OFFSET  = 2'd2;
	localparam logic [1:0] CFG_DEADBAND     = 2'd3;

	typedef struct packed {
		logic busy;
		logic done;
	} unit_sts_t;

	// atan(2^-i) in 2^-16 degree
	function automatic logic [21:0] atan_tab(input logic [4:0] i);
		logic [21:0] r;
		case (i)
			5'd0:    r = 22'd2949120;
			5'd1:    r = 22'd1740967;
			5'd2:    r = 22'd919879;
			5'd3:    r = 22'd466945;
			5'd4:    r = 22'd234379;
			5'd5:    r = 22'd117304;
			5'd6:    r = 22'd58666;
			5'd7:    r = 22'd29335;
			5'd8:    r = 22'd14668;
			5'd9:    r = 22'd7334;
			5'd10:   r = 22'd3667;
			5'd11:   r = 22'd1833;
			5'd12:   r = 22'd917;
			5'd13:   r = 22'd458;
			5'd14:   r = 22'd229;
			5'd15:   r = 22'd115;
			5'd16:   r = 22'd57;
			5'd17:   r = 22'd29;
			5'd18:   r = 22'd14;
			5'd19:   r = 22'd7;
			5'd20:   r = 22'd4;
			5'd21:   r = 22'd2;
			5'd22:   r = 22'd1;
			default: r = 22'd0;
		endcase
		return r;
	endfunction

endpackage

/* sv/itp_cordic.sv */
`timescale 1ns / 1ps
module itp_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [33:0] x0,
	input  logic signed [33:0] y0,
	output itp_pkg::unit_sts_t sts,
	output logic signed [15:0] angle
);
	import itp_pkg::*;

	logic signed [36:0] x_q, y_q, dx, dy;
	logic signed [25:0] z_q, za;
	logic signed [17:0] zr;
	logic [4:0] i_q;
	logic busy_q, done_q;
	logic signed [15:0] angle_q;

	assign dx = x_q >>> i_q;
	assign dy = y_q >>> i_q;
	assign za = 26'(signed'({1'b0, atan_tab(i_q)}));
	assign zr = 18'((z_q + 26'sd128) >>> 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				i_q <= '0;
				if (y0 == 34'sd0) begin
					angle_q <= 16'sd0;
					done_q  <= 1'b1;
				end else if (x0 == 34'sd0) begin
					angle_q <= (y0 > 34'sd0) ? ANGLE_LIM : -ANGLE_LIM;
					done_q  <= 1'b1;
				end else begin
					x_q    <= 37'(x0);
					y_q    <= 37'(y0);
					z_q    <= '0;
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (i_q < 5'(CORDIC_STEPS)) begin
					if (y_q > 37'sd0) begin
						x_q <= x_q + dy;
						y_q <= y_q - dx;
						z_q <= z_q + za;
					end else begin
						x_q <= x_q - dy;
						y_q <= y_q + dx;
						z_q <= z_q - za;
					end
					i_q <= i_q + 5'd1;
				end else begin
					if (zr > 18'(ANGLE_LIM))
						angle_q <= ANGLE_LIM;
					else if (zr < -18'(ANGLE_LIM))
						angle_q <= -ANGLE_LIM;
					else
						angle_q <= zr[15:0];
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign angle    = angle_q;

endmodule

/* sv/itp_div.sv */
`timescale 1ns / 1ps
module itp_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [16:0]        mag,
	input  logic [9:0]         den,
	output itp_pkg::unit_sts_t sts,
	output logic [28:0]        quo
);
	import itp_pkg::*;

	logic [28:0] dv_q;
	logic [9:0]  rem_q;
	logic [9:0]  den_q;
	logic [10:0] tr;
	logic [4:0]  cnt_q;
	logic busy_q, done_q;

	assign tr = {rem_q, dv_q[28]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				dv_q   <= {mag, 12'd0};
				rem_q  <= '0;
				den_q  <= den;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (tr >= {1'b0, den_q}) begin
					rem_q <= 10'(tr - {1'b0, den_q});
					dv_q  <= {dv_q[27:0], 1'b1};
				end else begin
					rem_q <= tr[9:0];
					dv_q  <= {dv_q[27:0], 1'b0};
				end
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quo      = dv_q;

endmodule

/* sv/imu_tilt_estimator.sv */
`timescale 1ns / 1ps
// Tilt estimator: each input word (accel x/y/z, gyro x/y) gives one output word with accel
// pitch/roll and gyro-integrated pitch/roll, all in 1/256 degree. From accept to output
// valid, a sample goes through squaring of accel y and z on one multiplier, a bit-by-bit
// square root, then two CORDIC vectoring passes on one shared CORDIC unit. The two gyro
// divides by refresh_rate run on one shared restoring divider alongside. Input is not ready
// while a sample is in work; a finished word waits in the output register while the next
// sample is taken. Config writes are always ready and must be issued while idle.
module imu_tilt_estimator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // accel_x, accel_y, accel_z, gyro_x, gyro_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [71:0] m_tdata,  // accel_pitch, accel_roll, gyro_pitch[16:0], gyro_roll[16:0], pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import itp_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_SQA    = 9'b000000010,
		ST_SQB    = 9'b000000100,
		ST_SQRT   = 9'b000001000,
		ST_CP_GO  = 9'b000010000,
		ST_CP_WT  = 9'b000100000,
		ST_CR_GO  = 9'b001000000,
		ST_CR_WT  = 9'b010000000,
		ST_FIN    = 9'b100000000
	} state_t;

	state_t state_q;

	logic [9:0]  refresh_q;
	logic signed [15:0] poff_q, roff_q;
	logic [14:0] dband_q;
	logic signed [31:0] pacc_q, racc_q;

	logic signed [15:0] ax_q, ay_q, az_q, gx_q, gy_q;
	logic [31:0] sq_q;
	logic [47:0] v_q, res_q, bit_q, trial;
	logic [4:0]  cnt_q;

	logic signed [15:0] mul_a;
	logic signed [31:0] prod;
	logic [31:0] sq_sum;

	logic signed [16:0] dp, dr, rnum;
	logic [16:0] mp, mr, rden;
	logic div_sel_q, div_ok_q, div_start;
	logic [16:0] div_mag;
	logic [9:0]  rr;
	logic [28:0] quo;
	unit_sts_t div_sts, cor_sts;
	logic signed [29:0] qp_q, qr_q, quo_s;

	logic cor_start;
	logic signed [33:0] cx0, cy0;
	logic signed [15:0] cor_angle, pitch_q, roll_q;

	logic out_free, fin_go;
	logic signed [32:0] sp, sr, satp, satr, nap, nar;
	logic [15:0] magp, magr;
	logic signed [32:0] rgp, rgr;

	assign s_tready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid || m_tready;
	assign fin_go    = (state_q == ST_FIN) && div_ok_q && out_free;

	// shared multiplier for the two squares
	assign mul_a  = (state_q == ST_SQA) ? ay_q : az_q;
	assign prod   = mul_a * mul_a;
	assign sq_sum = sq_q + 32'(prod);

	assign trial = res_q + bit_q;

	assign dp   = 17'(gy_q) - 17'(poff_q);
	assign dr   = 17'(gx_q) - 17'(roff_q);
	assign mp   = dp[16] ? 17'(-dp) : 17'(dp);
	assign mr   = dr[16] ? 17'(-dr) : 17'(dr);
	assign rr   = (refresh_q == 10'd0) ? 10'd1 : refresh_q;
	assign div_start = (state_q == ST_SQA) || (div_sts.done && !div_sel_q);
	assign div_mag   = (state_q == ST_SQA) ? mp : mr;
	assign quo_s     = (div_sel_q ? dr[16] : dp[16]) ? -30'(quo) : 30'(quo);

	itp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (div_mag),
		.den    (rr),
		.sts    (div_sts),
		.quo    (quo)
	);

	assign rden = az_q[15] ? 17'(-17'(az_q)) : 17'(az_q);
	assign rnum = az_q[15] ? -17'(ay_q) : 17'(ay_q);
	assign cor_start = (state_q == ST_CP_GO) || (state_q == ST_CR_GO);
	assign cx0 = (state_q == ST_CR_GO) ? {1'b0, rden, 16'd0} : {2'b00, res_q[23:0], 8'd0};
	assign cy0 = (state_q == ST_CR_GO) ? {rnum[16], rnum, 16'd0}
	                                   : {{2{ax_q[15]}}, ax_q, 16'd0};

	itp_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cor_start),
		.x0     (cx0),
		.y0     (cy0),
		.sts    (cor_sts),
		.angle  (cor_angle)
	);

	// integrators
	assign sp   = 33'(pacc_q) + 33'(qp_q);
	assign sr   = 33'(racc_q) + 33'(qr_q);
	assign satp = (sp > ACC_LIM) ? ACC_LIM : ((sp < -ACC_LIM) ? -ACC_LIM : sp);
	assign satr = (sr > ACC_LIM) ? ACC_LIM : ((sr < -ACC_LIM) ? -ACC_LIM : sr);
	assign magp = pitch_q[15] ? 16'(-pitch_q) : 16'(pitch_q);
	assign magr = roll_q[15] ? 16'(-roll_q) : 16'(roll_q);
	assign nap  = (magp < {1'b0, dband_q}) ? 33'sd0 : satp;
	assign nar  = (magr < {1'b0, dband_q}) ? 33'sd0 : satr;
	assign rgp  = (nap + 33'sd128) >>> 8;
	assign rgr  = (nar + 33'sd128) >>> 8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_q <= 10'd100;
			poff_q    <= '0;
			roff_q    <= '0;
			dband_q   <= 15'd64;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_REFRESH_RATE: refresh_q <= cfg_data[9:0];
				CFG_PITCH_OFFSET: poff_q    <= cfg_data;
				CFG_ROLL_OFFSET:  roff_q    <= cfg_data;
				CFG_DEADBAND:     dband_q   <= cfg_data[14:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			pacc_q    <= '0;
			racc_q    <= '0;
			m_tvalid  <= 1'b0;
			div_sel_q <= 1'b0;
			div_ok_q  <= 1'b0;
			cnt_q     <= '0;
		end else begin
			if (fin_go)
				m_tvalid <= 1'b1;
			else if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			if (div_sts.done) begin
				if (!div_sel_q) begin
					qp_q      <= quo_s;
					div_sel_q <= 1'b1;
				end else begin
					qr_q     <= quo_s;
					div_ok_q <= 1'b1;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ax_q      <= s_tdata[15:0];
						ay_q      <= s_tdata[31:16];
						az_q      <= s_tdata[47:32];
						gx_q      <= s_tdata[63:48];
						gy_q      <= s_tdata[79:64];
						div_sel_q <= 1'b0;
						div_ok_q  <= 1'b0;
						state_q   <= ST_SQA;
					end
				end
				ST_SQA: begin
					sq_q    <= 32'(prod);
					state_q <= ST_SQB;
				end
				ST_SQB: begin
					v_q     <= {sq_sum, 16'd0};
					res_q   <= '0;
					bit_q   <= 48'h4000_0000_0000;
					cnt_q   <= '0;
					state_q <= ST_SQRT;
				end
				ST_SQRT: begin
					if (v_q >= trial) begin
						v_q   <= v_q - trial;
						res_q <= (res_q >> 1) + bit_q;
					end else begin
						res_q <= res_q >> 1;
					end
					bit_q <= bit_q >> 2;
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(SQRT_STEPS - 1))
						state_q <= ST_CP_GO;
				end
				ST_CP_GO: state_q <= ST_CP_WT;
				ST_CP_WT: begin
					if (cor_sts.done) begin
						pitch_q <= cor_angle;
						state_q <= ST_CR_GO;
					end
				end
				ST_CR_GO: state_q <= ST_CR_WT;
				ST_CR_WT: begin
					if (cor_sts.done) begin
						roll_q  <= -cor_angle;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						pacc_q   <= 32'(nap);
						racc_q   <= 32'(nar);
						m_tdata  <= {6'd0, rgr[16:0], rgp[16:0], roll_q, pitch_q};
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_acc_range: assert property (@(posedge clk) disable iff (!arst_n)
		(33'(pacc_q) <= ACC_LIM) && (33'(pacc_q) >= -ACC_LIM)
		&& (33'(racc_q) <= ACC_LIM) && (33'(racc_q) >= -ACC_LIM))
		else $error("accumulator out of range");

	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && m_tvalid && !m_tready) |=> (state_q == ST_FIN))
		else $error("result overwritten while output stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("ready while sample in work");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && div_ok_q && out_free) |=> (m_tvalid && state_q == ST_IDLE))
		else $error("finish did not produce output");

endmodule
